// File: design/twisted_coordinate_map_assert.svh
// ----------------------------------------------------------------------------
// Twisted coordinate map assertion macros
// Clocked assertion wrappers used by the checker file tcm_checker.sv.
// ----------------------------------------------------------------------------
`ifndef TWISTED_COORDINATE_MAP_ASSERT_SVH
`define TWISTED_COORDINATE_MAP_ASSERT_SVH

// checked outside reset only
`define TCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define TCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/tcm_pkg.sv
// ----------------------------------------------------------------------------
// Twisted coordinate map package
// Register codes, angle constants and the CORDIC arctangent steps.
// ----------------------------------------------------------------------------
package tcm_pkg;

  localparam int FRAC_BITS_DEF = 24;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TWIST_RADIUS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TWIST_AMOUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_LEN_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_LEN_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_LEN_Z  = 3'd5;

  // Q30 angle constants, 35 bit signed; Q30 CORDIC gain, 34 bit signed; 2*pi also in Q61, 64 bit
  localparam logic signed [34:0] Q30_ONE      = 35'sd1073741824;
  localparam logic signed [34:0] TWO_PI_Q30   = 35'sd6746518852;
  localparam logic signed [34:0] PI_Q30       = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30  = 35'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic [63:0]        TWO_PI_Q61   = 64'hC90FDAA22168C235;
  localparam int                 CORDIC_STEPS = 30;

  function automatic logic signed [34:0] atan_step(input int i);
    logic signed [34:0] r;
    case (i)
      0: r = 35'sd843314857;
      1: r = 35'sd497837829;
      2: r = 35'sd263043837;
      3: r = 35'sd133525159;
      4: r = 35'sd67021687;
      5: r = 35'sd33543516;
      6: r = 35'sd16775851;
      7: r = 35'sd8388437;
      8: r = 35'sd4194283;
      9: r = 35'sd2097149;
      default: r = 35'sd1 <<< (30 - i);
    endcase
    return r;
  endfunction

endpackage

// File: design/twisted_coordinate_map.sv
// ----------------------------------------------------------------------------
// Twisted coordinate map
// Forward or inverse twist of one signed fixed point 3-D point per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries op, coord_x, coord_y, coord_z.
//   Output channel out_valid / out_stall carries out_x, out_y, out_z and
//   inside_twist, one result item per input item, in order.
//   Config writes go through cfg_valid / cfg_ready (always ready) with
//   cfg_index and cfg_data; write only while no items are in flight.
// Throughput: one item per cycle while a held result does not stall the pipe.
// Stages: the phase reduction has PH_STEPS = 62 - 2*FRAC_BITS stages
//   (1 once that drops below 1), the twist reduction B_STEPS = 32 - FRAC_BITS
//   (same floor). The 32 square root stages and the two 30 step CORDIC
//   pipelines make up most of the pipe; the two modulo reductions take one
//   quotient bit per stage.
// Stall: the whole pipeline shares one enable. While out_valid is high and
//   out_stall is high, every stage holds and in_stall is raised; nothing is
//   dropped or repeated. A free output register lets the pipe keep moving.
// Reset: clears all stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module twisted_coordinate_map #(
  parameter int FRAC_BITS = tcm_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic signed [31:0]            coord_x,
  input  logic signed [31:0]            coord_y,
  input  logic signed [31:0]            coord_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_x,
  output logic signed [31:0]            out_y,
  output logic signed [31:0]            out_z,
  output logic                          inside_twist,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  // offset width: holds -(L/2) +/- one unit
  localparam int OFW      = ((FRAC_BITS > 31) ? FRAC_BITS : 31) + 3;
  localparam int SA       = 1 + 3 * 32 + 3 * OFW;  // op, xi, offsets
  localparam int SB       = SA + 1;                // + inside
  localparam int SC       = SB + 1;                // + nonzero angle
  localparam int SD       = 2 + 32 + 3 * OFW;      // inside, op, z, offsets
  localparam int PH_STEPS = (2 * FRAC_BITS < 61) ? 62 - 2 * FRAC_BITS : 1;
  localparam int B_STEPS  = (FRAC_BITS < 31) ? 32 - FRAC_BITS : 1;
  localparam logic [63:0] TWO_PI_F = tcm_pkg::TWO_PI_Q61 >> (61 - FRAC_BITS);
  localparam int SHR = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
  localparam int SHL = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;
  localparam logic signed [63:0] UNIT = 64'sd1 <<< FRAC_BITS;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] calc_off(input logic signed [31:0] v,
                                                 input logic [30:0] len,
                                                 input logic fwd);
    logic signed [63:0] o;
    o = -$signed(64'(len >> 1));
    if (fwd && v[31]) o = o + UNIT;
    if (fwd && (64'(v) > $signed(64'(len)))) o = o - UNIT;
    return o;
  endfunction

  // rounded half up at 2^-30, saturated
  function automatic logic signed [31:0] rot(input logic signed [63:0] p);
    return sat32((p + 64'sd536870912) >>> 30);
  endfunction

  // ---------------- pipeline enable ----------------
  logic en;
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // ---------------- config registers ----------------
  logic [30:0]        twist_radius, radial_scale, dlen_x, dlen_y, dlen_z;
  logic signed [31:0] twist_amount;
  logic [31:0]        tmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      twist_radius <= 31'd16777216;
      twist_amount <= '0;
      radial_scale <= 31'd52707179;
      dlen_x       <= 31'd16777216;
      dlen_y       <= 31'd16777216;
      dlen_z       <= 31'd16777216;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcm_pkg::REG_TWIST_RADIUS: twist_radius <= cfg_data[30:0];
        tcm_pkg::REG_TWIST_AMOUNT: twist_amount <= $signed(cfg_data);
        tcm_pkg::REG_RADIAL_SCALE: radial_scale <= cfg_data[30:0];
        tcm_pkg::REG_DOMAIN_LEN_X: dlen_x       <= cfg_data[30:0];
        tcm_pkg::REG_DOMAIN_LEN_Y: dlen_y       <= cfg_data[30:0];
        tcm_pkg::REG_DOMAIN_LEN_Z: dlen_z       <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign tmag = twist_amount[31] ? 32'(-64'(twist_amount)) : twist_amount;

  // ---------------- P1: periodic offset ----------------
  logic                  v1, op1;
  logic signed [31:0]    x1, y1, z1;
  logic signed [OFW-1:0] ox1, oy1, oz1;
  logic signed [63:0]    ox_n, oy_n, oz_n;

  always_comb begin
    ox_n = calc_off(coord_x, dlen_x, !op);
    oy_n = calc_off(coord_y, dlen_y, !op);
    oz_n = calc_off(coord_z, dlen_z, !op);
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= op;
      ox1 <= ox_n[OFW-1:0];
      oy1 <= oy_n[OFW-1:0];
      oz1 <= oz_n[OFW-1:0];
      x1  <= sat32(64'(coord_x) + ox_n);
      y1  <= sat32(64'(coord_y) + oy_n);
      z1  <= sat32(64'(coord_z) + oz_n);
    end
  end

  // ---------------- P2: squares, P3: sum ----------------
  logic              v2, v3;
  logic [SA-1:0]     sa2, sa3;
  logic signed [63:0] sqx, sqy;
  logic [63:0]       r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= x1 * x1;
      sqy <= y1 * y1;
      sa2 <= {op1, x1, y1, z1, ox1, oy1, oz1};
      r2  <= $unsigned(sqx) + $unsigned(sqy);
      sa3 <= sa2;
    end
  end

  // ---------------- radius ----------------
  logic          vq;
  logic [31:0]   root;
  logic [SA-1:0] saq;

  tcm_isqrt #(.SW(SA)) u_isqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v3), .in_rad(r2), .in_side(sa3),
    .out_valid(vq), .out_root(root), .out_side(saq)
  );

  // ---------------- P4: inside test, phase product ----------------
  logic          v4;
  logic [SB-1:0] sb4;
  logic [62:0]   ph_prod;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= vq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb4     <= {(root < 32'(twist_radius)), saq};
      ph_prod <= radial_scale * root;
    end
  end

  // ---------------- phase modulo 2*pi ----------------
  logic          vp;
  logic [63:0]   phase;
  logic [SB-1:0] sbp;

  tcm_modred #(.SW(SB), .STEPS(PH_STEPS), .MODV(TWO_PI_F)) u_ph_mod (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v4), .in_val(64'(ph_prod) >> FRAC_BITS), .in_side(sb4),
    .out_valid(vp), .out_val(phase), .out_side(sbp)
  );

  // ---------------- cos of phase ----------------
  logic               vc1;
  logic signed [31:0] cos1, sin1_unused;
  logic [SB-1:0]      sbc1;
  logic [63:0]        pq30;

  assign pq30 = (phase >> SHR) << SHL;

  tcm_cordic #(.SW(SB)) u_cordic_ph (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vp), .in_mag(pq30[33:0]), .in_neg(1'b0), .in_side(sbp),
    .out_valid(vc1), .out_cos(cos1), .out_sin(sin1_unused), .out_side(sbc1)
  );

  // ---------------- P6..P10: alpha = (1 + cos)^3 / 2, beta = |twist| * alpha ----------------
  logic               v6, v7, v8, v9, v10;
  logic [SB-1:0]      sb6, sb7, sb8, sb9, sb10;
  logic signed [32:0] vs;
  logic [31:0]        val6, val7;
  logic [32:0]        vv7;
  logic [63:0]        vsq, cube8, bprod10, bmag;
  logic [31:0]        alpha9;

  assign vs   = 33'sd1073741824 + 33'(cos1);
  assign vsq  = 64'(val6) * 64'(val6);
  assign bmag = bprod10 >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else if (en) begin
      v6  <= vc1;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val6    <= vs[31:0];
      sb6     <= sbc1;
      vv7     <= vsq[62:30];
      val7    <= val6;
      sb7     <= sb6;
      cube8   <= 64'(vv7) * 64'(val7);
      sb8     <= sb7;
      alpha9  <= cube8[63] ? 32'hFFFFFFFF : cube8[62:31];
      sb9     <= sb8;
      bprod10 <= 64'(alpha9) * 64'(tmag);
      sb10    <= sb9;
    end
  end

  // ---------------- twist angle modulo 2*pi ----------------
  logic          vb;
  logic [63:0]   bred;
  logic [SC-1:0] scb;

  tcm_modred #(.SW(SC), .STEPS(B_STEPS), .MODV(64'(tcm_pkg::TWO_PI_Q30))) u_b_mod (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v10), .in_val(bmag), .in_side({(bmag != '0), sb10}),
    .out_valid(vb), .out_val(bred), .out_side(scb)
  );

  // ---------------- sin and cos of the twist ----------------
  logic               vc2;
  logic signed [31:0] cos2, sin2;
  logic [SC-1:0]      scc2;

  tcm_cordic #(.SW(SC)) u_cordic_b (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vb), .in_mag(bred[33:0]), .in_neg(twist_amount[31]), .in_side(scb),
    .out_valid(vc2), .out_cos(cos2), .out_sin(sin2), .out_side(scc2)
  );

  // ---------------- P11: pick rotation, zero angle or outside the twist gives identity ----------------
  logic                  nzc, insc, opc;
  logic signed [31:0]    xc, yc, zc;
  logic signed [OFW-1:0] oxc, oyc, ozc;
  logic                  v11;
  logic signed [31:0]    c11, s11, x11, y11;
  logic [SD-1:0]         sd11, sd12, sd13, sd14;

  assign {nzc, insc, opc, xc, yc, zc, oxc, oyc, ozc} = scc2;

  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (en) v11 <= vc2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c11  <= (insc && nzc) ? cos2 : 32'(tcm_pkg::Q30_ONE);
      s11  <= (insc && nzc) ? sin2 : '0;
      x11  <= xc;
      y11  <= yc;
      sd11 <= {insc, opc, zc, oxc, oyc, ozc};
    end
  end

  // ---------------- P12: products, P13: rounded terms, P14: sums ----------------
  logic               v12, v13, v14;
  logic signed [63:0] pcx, psy, pcy, psx;
  logic signed [31:0] tcx, tsy, tcy, tsx, rx14, ry14;
  logic               op13;

  assign op13 = sd13[SD-2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v12 <= 1'b0;
      v13 <= 1'b0;
      v14 <= 1'b0;
    end else if (en) begin
      v12 <= v11;
      v13 <= v12;
      v14 <= v13;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcx  <= c11 * x11;
      psy  <= s11 * y11;
      pcy  <= c11 * y11;
      psx  <= s11 * x11;
      sd12 <= sd11;
      tcx  <= rot(pcx);
      tsy  <= rot(psy);
      tcy  <= rot(pcy);
      tsx  <= rot(psx);
      sd13 <= sd12;
      if (!op13) begin
        rx14 <= sat32(64'(tcx) + 64'(tsy));
        ry14 <= sat32(64'(tcy) - 64'(tsx));
      end else begin
        rx14 <= sat32(64'(tcx) - 64'(tsy));
        ry14 <= sat32(64'(tcy) + 64'(tsx));
      end
      sd14 <= sd13;
    end
  end

  // ---------------- output register: undo offset ----------------
  logic                  ins14, op14_unused;
  logic signed [31:0]    z14;
  logic signed [OFW-1:0] ox14, oy14, oz14;

  assign {ins14, op14_unused, z14, ox14, oy14, oz14} = sd14;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v14;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x        <= sat32(64'(rx14) - 64'(ox14));
      out_y        <= sat32(64'(ry14) - 64'(oy14));
      out_z        <= sat32(64'(z14) - 64'(oz14));
      inside_twist <= ins14;
    end
  end

endmodule

// File: design/tcm_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64 bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module tcm_isqrt #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   in_rad,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [31:0]   out_root,
  output logic [SW-1:0] out_side
);

  localparam int N = 32;

  logic          vld  [N];
  logic [64:0]   rem  [N];
  logic [31:0]   root [N];
  logic [SW-1:0] sd   [N];

  for (genvar i = 0; i < N; i++) begin : g_st
    localparam int K = N - 1 - i;
    logic          v_in;
    logic [64:0]   rem_in;
    logic [31:0]   root_in;
    logic [SW-1:0] sd_in;
    logic [64:0]   trial;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = {1'b0, in_rad};
      assign root_in = '0;
      assign sd_in   = in_side;
    end else begin : g_rest
      assign v_in    = vld[i-1];
      assign rem_in  = rem[i-1];
      assign root_in = root[i-1];
      assign sd_in   = sd[i-1];
    end

    assign trial = (65'(root_in) << (K + 1)) + (65'd1 << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[i] <= sd_in;
        if (rem_in >= trial) begin
          rem[i]  <= rem_in - trial;
          root[i] <= root_in | (32'd1 << K);
        end else begin
          rem[i]  <= rem_in;
          root[i] <= root_in;
        end
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_root  = root[N-1];
  assign out_side  = sd[N-1];

endmodule

// File: design/tcm_modred.sv
// ----------------------------------------------------------------------------
// Pipelined modulo reduction
// Value modulo a constant by conditional subtraction, one quotient bit a stage.
// ----------------------------------------------------------------------------
module tcm_modred #(
  parameter int          SW    = 1,
  parameter int          STEPS = 1,
  parameter logic [63:0] MODV  = 64'd1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   in_val,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [63:0]   out_val,
  output logic [SW-1:0] out_side
);

  logic          vld [STEPS];
  logic [63:0]   val [STEPS];
  logic [SW-1:0] sd  [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_st
    localparam logic [63:0] SUBV = MODV << (STEPS - 1 - i);
    logic          v_in;
    logic [63:0]   val_in;
    logic [SW-1:0] sd_in;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign val_in = in_val;
      assign sd_in  = in_side;
    end else begin : g_rest
      assign v_in   = vld[i-1];
      assign val_in = val[i-1];
      assign sd_in  = sd[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[i]  <= sd_in;
        val[i] <= (val_in >= SUBV) ? val_in - SUBV : val_in;
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign out_val   = val[STEPS-1];
  assign out_side  = sd[STEPS-1];

endmodule

// File: design/tcm_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine and cosine
// Quadrant fold, 30 rotation stages and a clamp stage, Q30 in and out.
// ----------------------------------------------------------------------------
module tcm_cordic #(
  parameter int SW = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [33:0]        in_mag,
  input  logic               in_neg,
  input  logic [SW-1:0]      in_side,
  output logic               out_valid,
  output logic signed [31:0] out_cos,
  output logic signed [31:0] out_sin,
  output logic [SW-1:0]      out_side
);

  localparam int N = tcm_pkg::CORDIC_STEPS;

  // front: wrap and negate, then fold into [-pi/2, pi/2]
  logic               f1_vld, f2_vld;
  logic signed [34:0] f1_ang, f2_ang;
  logic               f2_flip;
  logic [SW-1:0]      f1_sd, f2_sd;
  logic [34:0]        m0, m1, m2;
  logic signed [34:0] b0;

  always_comb begin
    m0 = {1'b0, in_mag};
    m1 = (m0 >= 35'(tcm_pkg::TWO_PI_Q30)) ? m0 - 35'(tcm_pkg::TWO_PI_Q30) : m0;
    m2 = (in_neg && (m1 != '0)) ? 35'(tcm_pkg::TWO_PI_Q30) - m1 : m1;
    b0 = (f1_ang > tcm_pkg::PI_Q30) ? f1_ang - tcm_pkg::TWO_PI_Q30 : f1_ang;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
    end else if (en) begin
      f1_vld <= in_valid;
      f2_vld <= f1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_ang <= $signed(m2);
      f1_sd  <= in_side;
      f2_sd  <= f1_sd;
      if (b0 > tcm_pkg::HALF_PI_Q30) begin
        f2_ang  <= b0 - tcm_pkg::PI_Q30;
        f2_flip <= 1'b1;
      end else if (b0 < -tcm_pkg::HALF_PI_Q30) begin
        f2_ang  <= b0 + tcm_pkg::PI_Q30;
        f2_flip <= 1'b1;
      end else begin
        f2_ang  <= b0;
        f2_flip <= 1'b0;
      end
    end
  end

  // rotation stages
  logic               vld [N];
  logic signed [33:0] xs  [N];
  logic signed [33:0] ys  [N];
  logic signed [34:0] as  [N];
  logic               flp [N];
  logic [SW-1:0]      sd  [N];

  for (genvar i = 0; i < N; i++) begin : g_st
    localparam logic signed [34:0] STEP = tcm_pkg::atan_step(i);
    logic               v_in, f_in;
    logic signed [33:0] x_in, y_in;
    logic signed [34:0] a_in;
    logic [SW-1:0]      sd_in;

    if (i == 0) begin : g_first
      assign v_in  = f2_vld;
      assign x_in  = tcm_pkg::CORDIC_GAIN;
      assign y_in  = '0;
      assign a_in  = f2_ang;
      assign f_in  = f2_flip;
      assign sd_in = f2_sd;
    end else begin : g_rest
      assign v_in  = vld[i-1];
      assign x_in  = xs[i-1];
      assign y_in  = ys[i-1];
      assign a_in  = as[i-1];
      assign f_in  = flp[i-1];
      assign sd_in = sd[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        flp[i] <= f_in;
        sd[i]  <= sd_in;
        if (!a_in[34]) begin
          xs[i] <= x_in - (y_in >>> i);
          ys[i] <= y_in + (x_in >>> i);
          as[i] <= a_in - STEP;
        end else begin
          xs[i] <= x_in + (y_in >>> i);
          ys[i] <= y_in - (x_in >>> i);
          as[i] <= a_in + STEP;
        end
      end
    end
  end

  // unfold and clamp to [-1, 1]
  localparam logic signed [33:0] ONE34 = 34'sd1073741824;
  logic signed [33:0] xf, yf, xc, yc;
  logic               c_vld;
  logic [SW-1:0]      c_sd;

  always_comb begin
    xf = flp[N-1] ? -xs[N-1] : xs[N-1];
    yf = flp[N-1] ? -ys[N-1] : ys[N-1];
    xc = (xf > ONE34) ? ONE34 : ((xf < -ONE34) ? -ONE34 : xf);
    yc = (yf > ONE34) ? ONE34 : ((yf < -ONE34) ? -ONE34 : yf);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= vld[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cos <= xc[31:0];
      out_sin <= yc[31:0];
      c_sd    <= sd[N-1];
    end
  end

  assign out_valid = c_vld;
  assign out_side  = c_sd;

endmodule

// File: design/tcm_checker.sv
// ----------------------------------------------------------------------------
// Twisted coordinate map port checker
// Port level checks on reset, stall behavior and the result handshake.
// ----------------------------------------------------------------------------
`include "twisted_coordinate_map_assert.svh"

module tcm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_z,
  input logic               inside_twist
);

  // reset empties the pipe
  `TCM_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "out_valid high after reset")

  // input only stalls when a result is held back
  `TCM_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without cause")

  // held result keeps its payload
  `TCM_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(inside_twist)), "stalled result changed")

  // a stalled output with an item offered has the input stalled in the same cycle
  `TCM_ASSERT(a_stall_keep, (out_valid && out_stall && in_valid) |-> in_stall, "item taken while output blocked")

endmodule

bind twisted_coordinate_map tcm_checker u_tcm_checker (.*);

// File: dv/twisted_coordinate_map_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Twisted coordinate map testbench
// Streams 3-D points through the forward and inverse twist under several
// register settings, predicts each result in fixed point and compares it
// field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module twisted_coordinate_map_test;

  localparam int FB = 24;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               in_twist;
  } point_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic op = 0;
  logic signed [31:0] coord_x = 0, coord_y = 0, coord_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] out_x, out_y, out_z;
  logic inside_twist;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [tcm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  twisted_coordinate_map u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow registers
  longint m_radius, m_amount, m_scale;
  longint m_len [3];

  point_t expected_points [$];
  int  fail_count = 0;
  longint cycle_count = 0;
  bit  idle_enable = 1;

  // --- arithmetic helpers --------------------------------------------------
  function automatic longint clip32(longint v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  function automatic longint clip_unit(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint round_q30(longint p);
    return clip32((p + (64'sd1 <<< 29)) >>> 30);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned acc, bitv;
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  // CORDIC cos/sin in Q30 of angle magnitude with sign
  task automatic cordic_q30(input longint unsigned mag, input bit neg,
                            output longint c, output longint s);
    longint a, cx, cy, nx, stp, tp, pp, hp;
    bit flip;
    tp = tcm_pkg::TWO_PI_Q30;
    pp = tcm_pkg::PI_Q30;
    hp = tcm_pkg::HALF_PI_Q30;
    a = longint'(mag % longint'(tp));
    cx = tcm_pkg::CORDIC_GAIN;
    cy = 0;
    flip = 0;
    if (neg && a != 0) a = tp - a;
    if (a > pp) a -= tp;
    if (a > hp) begin
      a -= pp;
      flip = 1;
    end else if (a < -hp) begin
      a += pp;
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      if (i < 10) begin
        case (i)
          0: stp = 843314857;
          1: stp = 497837829;
          2: stp = 263043837;
          3: stp = 133525159;
          4: stp = 67021687;
          5: stp = 33543516;
          6: stp = 16775851;
          7: stp = 8388437;
          8: stp = 4194283;
          default: stp = 2097149;
        endcase
      end else begin
        stp = 64'sd1 <<< (30 - i);
      end
      if (a >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        a -= stp;
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        a += stp;
      end
      cx = nx;
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    c = clip_unit(cx);
    s = clip_unit(cy);
  endtask

  // full map of one point
  task automatic twist_point(input bit inv, input logic signed [31:0] px,
                             input logic signed [31:0] py,
                             input logic signed [31:0] pz, output point_t r);
    longint v [3];
    longint off [3], xi [3], res [3];
    longint c, s, cp, sp, o;
    longint unsigned r2, rad, phase, twopi, val, cube, alpha, tmag, bmag;
    v[0] = longint'(px);
    v[1] = longint'(py);
    v[2] = longint'(pz);
    c = 64'sd1073741824;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      o = -(m_len[k] >>> 1);
      if (!inv) begin
        if (v[k] < 0) o += 64'sd1 <<< FB;
        if (v[k] > m_len[k]) o -= 64'sd1 <<< FB;
      end
      off[k] = o;
      xi[k] = clip32(v[k] + o);
    end
    r2 = longint'(xi[0] * xi[0]) + longint'(xi[1] * xi[1]);
    rad = int_sqrt(r2);
    r.in_twist = rad < longint'(m_radius);
    if (r.in_twist) begin
      phase = (longint'(m_scale) * rad) >> FB;
      twopi = tcm_pkg::TWO_PI_Q61 >> (61 - FB);
      phase = phase % twopi;
      cordic_q30(phase << (30 - FB), 1'b0, cp, sp);
      val = 64'sd1073741824 + cp;
      cube = (((val * val) >> 30) * val) >> 30;
      alpha = cube >> 1;
      if (alpha > 64'hFFFFFFFF) alpha = 64'hFFFFFFFF;
      tmag = m_amount < 0 ? -m_amount : m_amount;
      bmag = (alpha * tmag) >> FB;
      if (bmag != 0) cordic_q30(bmag, m_amount < 0, c, s);
    end
    if (!inv) begin
      res[0] = clip32(round_q30(c * xi[0]) + round_q30(s * xi[1]));
      res[1] = clip32(round_q30(c * xi[1]) - round_q30(s * xi[0]));
    end else begin
      res[0] = clip32(round_q30(c * xi[0]) - round_q30(s * xi[1]));
      res[1] = clip32(round_q30(c * xi[1]) + round_q30(s * xi[0]));
    end
    res[2] = xi[2];
    r.x = 32'(clip32(res[0] - off[0]));
    r.y = 32'(clip32(res[1] - off[1]));
    r.z = 32'(clip32(res[2] - off[2]));
  endtask

  // --- channel tasks -------------------------------------------------------
  // in_valid stays high between back to back items; it drops on idling
  task automatic send_point(input bit p_op, input logic signed [31:0] px,
                            input logic signed [31:0] py,
                            input logic signed [31:0] pz);
    point_t e;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    twist_point(p_op, px, py, pz, e);
    expected_points.push_back(e);
    in_valid <= 1;
    op <= p_op;
    coord_x <= px;
    coord_y <= py;
    coord_z <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_empty();
    in_valid <= 0;
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  // idle the block, then write one register
  task automatic write_reg(input logic [tcm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] d);
    wait_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      tcm_pkg::REG_TWIST_RADIUS: m_radius = longint'(d & 32'h7FFFFFFF);
      tcm_pkg::REG_TWIST_AMOUNT: m_amount = longint'(signed'(d));
      tcm_pkg::REG_RADIAL_SCALE: m_scale = longint'(d & 32'h7FFFFFFF);
      tcm_pkg::REG_DOMAIN_LEN_X: m_len[0] = longint'(d & 32'h7FFFFFFF);
      tcm_pkg::REG_DOMAIN_LEN_Y: m_len[1] = longint'(d & 32'h7FFFFFFF);
      tcm_pkg::REG_DOMAIN_LEN_Z: m_len[2] = longint'(d & 32'h7FFFFFFF);
      default: ;
    endcase
  endtask

  // points mostly near the twist region, some anywhere
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h03000000) - 32'h01800000;
      default: return $urandom_range(0, 32'h00C00000) + 32'h00200000;
    endcase
  endfunction

  // --- output side ---------------------------------------------------------
  always @(posedge clk) begin
    point_t e;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        e = expected_points.pop_front();
        if (out_x !== e.x) begin
          $error("out_x expected %0d actual %0d", e.x, out_x);
          fail_count++;
        end
        if (out_y !== e.y) begin
          $error("out_y expected %0d actual %0d", e.y, out_y);
          fail_count++;
        end
        if (out_z !== e.z) begin
          $error("out_z expected %0d actual %0d", e.z, out_z);
          fail_count++;
        end
        if (inside_twist !== e.in_twist) begin
          $error("inside_twist expected %0d actual %0d", e.in_twist, inside_twist);
          fail_count++;
        end
      end
    end
  end

  // receiver stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_stall <= 0;
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("twisted_coordinate_map: mismatch");
    $finish;
  end

  // --- tests ---------------------------------------------------------------
  task automatic test_directed();
    send_point(0, 0, 0, 0);
    send_point(1, 0, 0, 0);
    send_point(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_point(1, 32'h80000000, 32'h80000000, 32'h80000000);
    send_point(0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_point(1, 32'h7FFFFFFF, 32'h80000000, 32'h00000001);
    send_point(0, 32'h00800000, 32'h00800000, 32'h00800000); // center
    send_point(0, 32'h01000000, 32'h01000000, 32'h01000000); // at length
    send_point(0, 32'h01000001, 32'hFFFFFFFF, 32'h01000001); // just past
    send_point(1, 32'h00900000, 32'h00800000, 32'h00000000);
    send_point(0, 32'h00C00000, 32'h00400000, 32'h12345678);
    send_point(1, 32'h00400000, 32'h00C00000, 32'hEDCBA987);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++)
      send_point(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic test_twist_settings();
    write_reg(tcm_pkg::REG_TWIST_AMOUNT, 32'h0324_3F6A);  // about pi
    test_directed();
    test_random(250);
    write_reg(tcm_pkg::REG_TWIST_AMOUNT, 32'h8000_0000);  // most negative
    write_reg(tcm_pkg::REG_TWIST_RADIUS, 32'h0080_0000);
    write_reg(tcm_pkg::REG_RADIAL_SCALE, 32'h0648_7ED5);
    test_random(200);
    // sender holds off until the pipeline drains
    wait_empty();
    write_reg(tcm_pkg::REG_TWIST_AMOUNT, 32'h7FFF_FFFF);
    write_reg(tcm_pkg::REG_TWIST_RADIUS, 32'h7FFF_FFFF);
    write_reg(tcm_pkg::REG_RADIAL_SCALE, 32'h7FFF_FFFF);
    test_directed();
    test_random(200);
  endtask

  task automatic test_domain_settings();
    write_reg(tcm_pkg::REG_DOMAIN_LEN_X, 32'h0);
    write_reg(tcm_pkg::REG_DOMAIN_LEN_Y, 32'h7FFF_FFFF);
    write_reg(tcm_pkg::REG_DOMAIN_LEN_Z, 32'hFFFF_FFFF);  // top bit ignored
    write_reg(tcm_pkg::REG_TWIST_RADIUS, 32'h0100_0000);
    write_reg(tcm_pkg::REG_RADIAL_SCALE, 32'h0324_3F6B);
    write_reg(tcm_pkg::REG_TWIST_AMOUNT, 32'hFE00_0000);
    test_directed();
    test_random(200);
    write_reg(tcm_pkg::REG_DOMAIN_LEN_X, 32'h0300_0001);
    write_reg(tcm_pkg::REG_DOMAIN_LEN_Y, 32'h0000_0001);
    write_reg(tcm_pkg::REG_DOMAIN_LEN_Z, 32'h0100_0000);
    write_reg(tcm_pkg::REG_TWIST_RADIUS, 32'h0);
    test_random(100);
    write_reg(tcm_pkg::REG_TWIST_RADIUS, 32'h0200_0000);
    write_reg(tcm_pkg::REG_DOMAIN_LEN_Y, 32'h0100_0000);
    write_reg(tcm_pkg::REG_TWIST_AMOUNT, 32'h0100_0000);
  endtask

  task automatic test_no_idle();
    idle_enable = 0;
    test_random(300);
  endtask

  initial begin
    m_radius = 16777216;
    m_amount = 0;
    m_scale = 52707179;
    m_len[0] = 16777216;
    m_len[1] = 16777216;
    m_len[2] = 16777216;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();       // reset values: zero twist
    test_random(50);
    test_twist_settings();
    test_domain_settings();
    test_no_idle();
    wait_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_points.size() == 0)
      $display("twisted_coordinate_map: match");
    else
      $display("twisted_coordinate_map: mismatch");
    $finish;
  end

endmodule
